// ----- src/rar_pkg.sv -----
package rar_pkg;

    localparam int ADDR_W           = 48;
    localparam int TOTAL_W          = 32;
    localparam int ATT_W            = 7;
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int MAX_ATTEMPTS_DEF  = 100;

    // first byte sits in bits 47:40
    localparam int LOCAL_POS = 41;
    localparam int MCAST_POS = 40;

    // register indexes of the config port
    localparam bit REG_KEEP_UNICAST = 1'b0;
    localparam bit REG_KEEP_LOCAL   = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT      = 2'd0,
        OP_ROTATE    = 2'd1,
        OP_READ_CUR  = 2'd2,
        OP_READ_ORIG = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_INIT = 2'd1,
        ST_RETRY    = 2'd2
    } t_status;

    // set local bit, clear multicast bit
    function automatic logic [ADDR_W-1:0] form_addr(input logic [ADDR_W-1:0] rnd);
        logic [ADDR_W-1:0] a;
        a = rnd;
        a[LOCAL_POS] = 1'b1;
        a[MCAST_POS] = 1'b0;
        return a;
    endfunction

endpackage

// ----- src/rar_in_if.sv -----
interface rar_in_if import rar_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [ADDR_W-1:0] given_address;
    logic [ADDR_W-1:0] random_bits;

    modport source (output valid, operation, given_address, random_bits, input ready);
    modport sink (input valid, operation, given_address, random_bits, output ready);
endinterface

// ----- src/rar_out_if.sv -----
interface rar_out_if import rar_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  address_out;
    logic [TOTAL_W-1:0] rotations_done;

    modport source (output valid, status, address_out, rotations_done, input ready);
    modport sink (input valid, status, address_out, rotations_done, output ready);
endinterface

// ----- src/rar_ram.sv -----
module rar_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/random_address_rotator_with_history.sv -----
// path: read and not-initialized answers go from idle to done, init passes through
// init2 first, a rotate candidate through a scan of the history fill (up to HISTORY_DEPTH)
// throughput: one transaction at a time, set by the one-entry-per-cycle history scan
// through the single read port of the history ram
// reset (synchronous, active low): not initialized, history empty, counters and
// addresses zero, both keep bits set; history ram contents are not cleared
module random_address_rotator_with_history import rar_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int MAX_ATTEMPTS  = MAX_ATTEMPTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rar_in_if.sink    i_in,
    rar_out_if.source o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic      i_cfg_wdata
);
    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_INIT2 = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // architectural state
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_oldest;
    logic [ADDR_W-1:0]  r_original;
    logic [ADDR_W-1:0]  r_current;
    logic               r_ready_flag;
    logic [ATT_W-1:0]   r_attempt;
    logic [TOTAL_W-1:0] r_total;
    logic               r_keep_unicast;
    logic               r_keep_local;

    // working registers for the transaction in flight
    logic [ADDR_W-1:0]  r_cand;
    logic [CNT_W-1:0]   r_left;
    logic [IDX_W-1:0]   r_rd_ptr;
    logic               r_cmp_valid;
    logic               r_hit;
    t_status            r_res_status;
    logic [ADDR_W-1:0]  r_res_addr;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [TOTAL_W-1:0] r_out_total;

    logic               in_fire;
    t_op                op;
    logic [ADDR_W-1:0]  cand;
    logic               scan_end;
    logic [ATT_W-1:0]   att_inc;
    logic               accept_cand;
    logic               out_free;

    // history record: append while filling, overwrite oldest when full
    logic               rec_do;
    logic               rec_base_zero;
    logic [ADDR_W-1:0]  rec_val;
    logic [CNT_W-1:0]   rec_cnt_in;
    logic [IDX_W-1:0]   rec_old_in;
    logic [IDX_W:0]     rec_sum;
    logic [IDX_W:0]     rec_inc;
    logic [IDX_W-1:0]   rec_slot;
    logic [CNT_W-1:0]   rec_cnt_nx;
    logic [IDX_W-1:0]   rec_old_nx;
    logic [IDX_W:0]     ptr_inc;
    logic [IDX_W-1:0]   ptr_nx;
    logic [ADDR_W-1:0]  mem_rdata;

    assign in_fire  = i_in.valid && i_in.ready;
    assign op       = t_op'(i_in.operation);
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    // candidate, with the keep options following the original address
    always_comb begin
        cand = form_addr(i_in.random_bits);
        if (r_keep_unicast && !r_original[MCAST_POS]) begin
            cand[MCAST_POS] = 1'b0;
        end
        if (r_keep_local && r_original[LOCAL_POS]) begin
            cand[LOCAL_POS] = 1'b1;
        end
    end

    // scan is done once all reads are issued and the last compare has landed
    assign scan_end    = (r_state == S_SCAN) && (r_left == '0) && !r_cmp_valid;
    assign att_inc     = r_attempt + ATT_W'(1);
    assign accept_cand = !r_hit || (att_inc >= ATT_W'(MAX_ATTEMPTS));

    always_comb begin
        rec_do        = 1'b0;
        rec_base_zero = 1'b0;
        rec_val       = r_current;
        priority if (r_state == S_IDLE && in_fire && op == OP_INIT) begin
            rec_do        = 1'b1;
            rec_base_zero = 1'b1;
            rec_val       = i_in.given_address;
        end else if (r_state == S_IDLE && in_fire && op == OP_ROTATE && r_ready_flag
                     && r_attempt == '0) begin
            // first candidate of a rotation records the current address
            rec_do  = 1'b1;
            rec_val = r_current;
        end else if (r_state == S_INIT2) begin
            rec_do  = 1'b1;
            rec_val = r_current;
        end else if (scan_end && accept_cand) begin
            rec_do  = 1'b1;
            rec_val = r_cand;
        end else begin
            rec_do  = 1'b0;
        end
    end

    assign rec_cnt_in = rec_base_zero ? '0 : r_count;
    assign rec_old_in = rec_base_zero ? '0 : r_oldest;
    assign rec_sum    = {1'b0, rec_old_in} + (IDX_W+1)'(rec_cnt_in);
    assign rec_inc    = {1'b0, rec_old_in} + (IDX_W+1)'(1);

    always_comb begin
        if (rec_cnt_in < CNT_W'(HISTORY_DEPTH)) begin
            if (rec_sum >= (IDX_W+1)'(HISTORY_DEPTH)) begin
                rec_slot = IDX_W'(rec_sum - (IDX_W+1)'(HISTORY_DEPTH));
            end else begin
                rec_slot = rec_sum[IDX_W-1:0];
            end
            rec_cnt_nx = rec_cnt_in + CNT_W'(1);
            rec_old_nx = rec_old_in;
        end else begin
            rec_slot   = rec_old_in;
            rec_cnt_nx = rec_cnt_in;
            if (rec_inc >= (IDX_W+1)'(HISTORY_DEPTH)) begin
                rec_old_nx = IDX_W'(rec_inc - (IDX_W+1)'(HISTORY_DEPTH));
            end else begin
                rec_old_nx = rec_inc[IDX_W-1:0];
            end
        end
    end

    // scan pointer walks the ring from the oldest entry
    assign ptr_inc = {1'b0, r_rd_ptr} + (IDX_W+1)'(1);
    assign ptr_nx  = (ptr_inc >= (IDX_W+1)'(HISTORY_DEPTH))
                   ? IDX_W'(ptr_inc - (IDX_W+1)'(HISTORY_DEPTH)) : ptr_inc[IDX_W-1:0];

    // writes land before a scan starts or after its last compare,
    // so no read ever overlaps a pending write
    rar_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (rec_do),
        .i_waddr (rec_slot),
        .i_wdata (rec_val),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (op == OP_INIT) begin
                        n_state = S_INIT2;
                    end else if (op == OP_ROTATE && r_ready_flag) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INIT2: n_state = S_DONE;
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_oldest       <= '0;
            r_original     <= '0;
            r_current      <= '0;
            r_ready_flag   <= 1'b0;
            r_attempt      <= '0;
            r_total        <= '0;
            r_keep_unicast <= 1'b1;
            r_keep_local   <= 1'b1;
            r_cmp_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_index == REG_KEEP_UNICAST) begin
                    r_keep_unicast <= i_cfg_wdata;
                end else begin
                    r_keep_local <= i_cfg_wdata;
                end
            end

            if (rec_do) begin
                r_count  <= rec_cnt_nx;
                r_oldest <= rec_old_nx;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (op)
                            OP_INIT: begin
                                r_original     <= i_in.given_address;
                                r_current      <= form_addr(i_in.random_bits);
                                r_ready_flag   <= 1'b1;
                                r_attempt      <= '0;
                                r_total        <= '0;
                                r_keep_unicast <= 1'b1;
                                r_keep_local   <= 1'b1;
                                r_res_status   <= ST_OK;
                                r_res_addr     <= form_addr(i_in.random_bits);
                            end
                            OP_ROTATE: begin
                                r_cand      <= cand;
                                r_hit       <= 1'b0;
                                r_cmp_valid <= 1'b0;
                                if (r_attempt == '0) begin
                                    r_left   <= rec_cnt_nx;
                                    r_rd_ptr <= rec_old_nx;
                                end else begin
                                    r_left   <= r_count;
                                    r_rd_ptr <= r_oldest;
                                end
                                r_res_status <= ST_NOT_INIT;
                                r_res_addr   <= '0;
                            end
                            OP_READ_CUR: begin
                                if (r_ready_flag) begin
                                    r_res_status <= ST_OK;
                                    r_res_addr   <= r_current;
                                end else begin
                                    r_res_status <= ST_NOT_INIT;
                                    r_res_addr   <= '0;
                                end
                            end
                            OP_READ_ORIG: begin
                                r_res_status <= ST_OK;
                                r_res_addr   <= r_original;
                            end
                            default: ;
                        endcase
                    end
                end
                S_INIT2: ;
                S_SCAN: begin
                    // issue one read a cycle, compare the entry read last cycle
                    if (r_left != '0) begin
                        r_rd_ptr    <= ptr_nx;
                        r_left      <= r_left - CNT_W'(1);
                        r_cmp_valid <= 1'b1;
                    end else begin
                        r_cmp_valid <= 1'b0;
                    end
                    if (r_cmp_valid && mem_rdata == r_cand) begin
                        r_hit <= 1'b1;
                    end
                    if (scan_end) begin
                        r_res_addr <= r_cand;
                        if (accept_cand) begin
                            r_current    <= r_cand;
                            r_total      <= r_total + TOTAL_W'(1);
                            r_attempt    <= '0;
                            r_res_status <= ST_OK;
                        end else begin
                            r_attempt    <= att_inc;
                            r_res_status <= ST_RETRY;
                        end
                    end
                end
                S_DONE: ;
                default: ;
            endcase

            // output register: load on finish, drop when taken
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload needs no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
            r_out_total  <= r_total;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.address_out    = r_out_addr;
    assign o_out.rotations_done = r_out_total;

endmodule

// ----- sim/tb_random_address_rotator_with_history.sv -----
typedef struct packed {
    rar_pkg::t_status            status;
    logic [rar_pkg::ADDR_W-1:0]  address;
    logic [rar_pkg::TOTAL_W-1:0] rotations;
} t_rotator_answer;

function automatic logic [rar_pkg::ADDR_W-1:0] random_address();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[rar_pkg::ADDR_W-1:0];
endfunction

// tracks original, current and recent addresses, predicts each answer
class t_address_history_tracker;
    logic [rar_pkg::ADDR_W-1:0]  recent [rar_pkg::HISTORY_DEPTH_DEF];
    int unsigned                 recent_fill;
    int unsigned                 recent_head;
    logic [rar_pkg::ADDR_W-1:0]  original;
    logic [rar_pkg::ADDR_W-1:0]  current;
    bit                          initialized;
    int unsigned                 open_attempts;
    logic [rar_pkg::TOTAL_W-1:0] rotations;
    bit                          keep_unicast;
    bit                          keep_local;
    t_rotator_answer             answers[$];
    int unsigned                 failures;

    function new();
        recent_fill   = 0;
        recent_head   = 0;
        original      = '0;
        current       = '0;
        initialized   = 1'b0;
        open_attempts = 0;
        rotations     = '0;
        keep_unicast  = 1'b1;
        keep_local    = 1'b1;
        failures      = 0;
    endfunction

    function void set_register(bit index, bit value);
        if (index == rar_pkg::REG_KEEP_UNICAST) begin
            keep_unicast = value;
        end else begin
            keep_local = value;
        end
    endfunction

    // oldest entry is overwritten once the history is full
    function void push_recent(logic [rar_pkg::ADDR_W-1:0] a);
        if (recent_fill < rar_pkg::HISTORY_DEPTH_DEF) begin
            recent[(recent_head + recent_fill) % rar_pkg::HISTORY_DEPTH_DEF] = a;
            recent_fill++;
        end else begin
            recent[recent_head] = a;
            recent_head = (recent_head + 1) % rar_pkg::HISTORY_DEPTH_DEF;
        end
    endfunction

    function logic [rar_pkg::ADDR_W-1:0] any_recent();
        if (recent_fill == 0) begin
            return random_address();
        end
        return recent[(recent_head + $urandom_range(recent_fill - 1))
                      % rar_pkg::HISTORY_DEPTH_DEF];
    endfunction

    function void note_request(rar_pkg::t_op op, logic [rar_pkg::ADDR_W-1:0] given,
                               logic [rar_pkg::ADDR_W-1:0] rnd);
        t_rotator_answer             ans;
        logic [rar_pkg::ADDR_W-1:0]  cand;
        bit                          hit;
        int unsigned                 i;
        ans.status  = rar_pkg::ST_OK;
        ans.address = '0;
        case (op)
            rar_pkg::OP_INIT: begin
                recent_fill   = 0;
                recent_head   = 0;
                open_attempts = 0;
                rotations     = '0;
                keep_unicast  = 1'b1;
                keep_local    = 1'b1;
                original      = given;
                current       = rnd;
                current[rar_pkg::LOCAL_POS] = 1'b1;
                current[rar_pkg::MCAST_POS] = 1'b0;
                push_recent(original);
                push_recent(current);
                initialized = 1'b1;
                ans.address = current;
            end
            rar_pkg::OP_ROTATE: begin
                if (!initialized) begin
                    ans.status = rar_pkg::ST_NOT_INIT;
                end else begin
                    cand = rnd;
                    cand[rar_pkg::LOCAL_POS] = 1'b1;
                    cand[rar_pkg::MCAST_POS] = 1'b0;
                    if (open_attempts == 0) begin
                        push_recent(current);
                    end
                    if (keep_unicast && !original[rar_pkg::MCAST_POS]) begin
                        cand[rar_pkg::MCAST_POS] = 1'b0;
                    end
                    if (keep_local && original[rar_pkg::LOCAL_POS]) begin
                        cand[rar_pkg::LOCAL_POS] = 1'b1;
                    end
                    open_attempts = (open_attempts + 1) & 'h7f;
                    hit = 1'b0;
                    for (i = 0; i < recent_fill; i++) begin
                        if (recent[(recent_head + i) % rar_pkg::HISTORY_DEPTH_DEF] == cand) begin
                            hit = 1'b1;
                        end
                    end
                    ans.address = cand;
                    if (hit && open_attempts < rar_pkg::MAX_ATTEMPTS_DEF) begin
                        ans.status = rar_pkg::ST_RETRY;
                    end else begin
                        current = cand;
                        push_recent(cand);
                        rotations++;
                        open_attempts = 0;
                    end
                end
            end
            rar_pkg::OP_READ_CUR: begin
                if (!initialized) begin
                    ans.status = rar_pkg::ST_NOT_INIT;
                end else begin
                    ans.address = current;
                end
            end
            default: begin
                ans.address = original;
            end
        endcase
        ans.rotations = rotations;
        answers.push_back(ans);
    endfunction

    function void check_answer(logic [1:0] status, logic [rar_pkg::ADDR_W-1:0] address,
                               logic [rar_pkg::TOTAL_W-1:0] rotations_done);
        t_rotator_answer want;
        if (answers.size() == 0) begin
            $error("result transaction with no request outstanding: status %0d address %h",
                   status, address);
            failures++;
            return;
        end
        want = answers.pop_front();
        if (status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status);
            failures++;
        end
        if (address !== want.address) begin
            $error("address_out expected %h actual %h", want.address, address);
            failures++;
        end
        if (rotations_done !== want.rotations) begin
            $error("rotations_done expected %0d actual %0d", want.rotations, rotations_done);
            failures++;
        end
    endfunction
endclass

module tb_random_address_rotator_with_history;
    import rar_pkg::*;

    // far above the slowest legal run (about 1250 transactions)
    localparam int CYCLE_LIMIT  = 400000;
    // long enough for the longest answer, a rotate that scans a full history
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 300;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_index;
    logic cfg_wdata;

    rar_in_if  in_if ();
    rar_out_if out_if ();

    t_address_history_tracker tracker = new();

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned requests_sent      = 0;
    int unsigned cycles             = 0;

    random_address_rotator_with_history i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side: ready changes on the falling edge, stalls at the phase's rate
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // a result transaction completes at the rising edge with valid and ready high
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            tracker.check_answer(out_if.status, out_if.address_out, out_if.rotations_done);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_random_address_rotator_with_history NOT OK");
            $finish;
        end
    end

    // bits 41:40 are forced by the block, so any value there still repeats an address it formed
    function automatic logic [ADDR_W-1:0] near_copy(logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        r = a;
        r[LOCAL_POS:MCAST_POS] = 2'($urandom_range(3));
        return r;
    endfunction

    // called and returns on a falling edge; valid stays high into the next request
    task automatic send_request(t_op op, logic [ADDR_W-1:0] given, logic [ADDR_W-1:0] rnd);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.operation     <= op;
        in_if.given_address <= given;
        in_if.random_bits   <= rnd;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        tracker.note_request(op, given, rnd);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // every request answers once, so an empty queue means the block is idle
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (tracker.answers.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(bit index, bit value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        tracker.set_register(index, value);
        @(negedge i_clk);
    endtask

    // random traffic: mostly complete rotations, some reads, occasional inits, a little noise
    task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned count,
                             bit with_streak);
        int unsigned start;
        int unsigned streak_at;
        int unsigned pick;
        bit          streak_done;
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        start       = requests_sent;
        streak_at   = start + $urandom_range(count / 2);
        streak_done = !with_streak;
        while (requests_sent - start < count) begin
            if (!streak_done && requests_sent >= streak_at) begin
                // keep repeating the current address until the attempt cap forces acceptance
                do begin
                    send_request(OP_ROTATE, random_address(), near_copy(tracker.current));
                end while (tracker.open_attempts != 0);
                streak_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_request(OP_INIT, ($urandom_range(7) == 0) ? '1 : random_address(),
                             random_address());
            end else if (pick < 64) begin
                // one full rotation: candidates until one is accepted, half of them near copies of recent addresses
                do begin
                    if ($urandom_range(4) == 0) begin
                        send_request(t_op'($urandom_range(1) ? OP_READ_CUR : OP_READ_ORIG),
                                     random_address(), random_address());
                    end
                    send_request(OP_ROTATE, random_address(),
                                 $urandom_range(1) ? near_copy(tracker.any_recent())
                                                   : random_address());
                end while (tracker.open_attempts != 0);
            end else if (pick < 86) begin
                send_request(t_op'($urandom_range(1) ? OP_READ_CUR : OP_READ_ORIG),
                             random_address(), random_address());
            end else begin
                // noise: any operation, may leave a rotation open
                send_request(t_op'($urandom_range(3)), random_address(), random_address());
            end
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_KEEP_UNICAST;
        cfg_wdata           = 1'b0;
        in_if.valid         = 1'b0;
        in_if.operation     = OP_INIT;
        in_if.given_address = '0;
        in_if.random_bits   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_register(REG_KEEP_UNICAST, 1'b0);
        write_register(REG_KEEP_LOCAL, 1'b0);

        // nothing initialized yet: original reads as zero, the rest say not initialized
        send_request(OP_READ_ORIG, '1, '1);
        send_request(OP_READ_CUR, '1, '1);
        send_request(OP_ROTATE, '1, '1);

        // init with an all-ones multicast original, all-zero random bits
        send_request(OP_INIT, '1, '0);
        send_request(OP_READ_CUR, '0, '0);
        send_request(OP_READ_ORIG, '0, '0);
        // fresh candidate, accepted at once
        send_request(OP_ROTATE, '0, '1);
        // candidate repeating the current address opens a rotation with a retry
        send_request(OP_ROTATE, '0, tracker.current);
        // reads leave the open rotation alone
        send_request(OP_READ_CUR, '1, '0);
        // zero random bits give the address formed at init, still in the history
        send_request(OP_ROTATE, '0, '0);
        send_request(OP_ROTATE, '0, 48'h1234_5678_9abc);

        // local unicast original equal to its own formed address
        send_request(OP_INIT, 48'h0a1b_2c3d_4e5f, 48'h0a1b_2c3d_4e5f);
        send_request(OP_ROTATE, '1, 48'h0a1b_2c3d_4e5f);
        // multicast bit of the candidate is cleared, so this repeats too
        send_request(OP_ROTATE, '1, 48'h0b1b_2c3d_4e5f);
        send_request(OP_ROTATE, '1, '1);
        send_request(OP_READ_ORIG, '0, '1);

        // all-zero original
        send_request(OP_INIT, '0, '1);
        send_request(OP_READ_ORIG, '1, '0);
        send_request(OP_ROTATE, '1, 48'h5a5a_a5a5_5a5a);

        // phases of random traffic, config changed between them while idle
        wait_idle();
        write_register(REG_KEEP_UNICAST, 1'b0);
        write_register(REG_KEEP_LOCAL, 1'b0);
        run_phase(0, 0, PHASE_ITEMS, 1'b1);

        wait_idle();
        write_register(REG_KEEP_UNICAST, 1'b1);
        write_register(REG_KEEP_LOCAL, 1'b0);
        run_phase(63, 0, PHASE_ITEMS, 1'b0);

        wait_idle();
        write_register(REG_KEEP_UNICAST, 1'b0);
        write_register(REG_KEEP_LOCAL, 1'b1);
        run_phase(0, 63, PHASE_ITEMS, 1'b0);

        wait_idle();
        write_register(REG_KEEP_UNICAST, 1'b1);
        write_register(REG_KEEP_LOCAL, 1'b1);
        run_phase(26, 26, PHASE_ITEMS, 1'b1);

        // drain, then give any stray result time to show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (tracker.failures == 0 && tracker.answers.size() == 0) begin
            $display("tb_random_address_rotator_with_history OK");
        end else begin
            $display("tb_random_address_rotator_with_history NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/rar_pkg.sv
src/rar_in_if.sv
src/rar_out_if.sv
src/rar_ram.sv
src/random_address_rotator_with_history.sv
sim/tb_random_address_rotator_with_history.sv
